// ===== src/cnthdr_pkg.sv =====
// Package: shared types, constants and helpers for the container header checker.
`timescale 1ns / 1ps
package cnthdr_pkg;

  localparam int unsigned SpanW       = 63;
  localparam int unsigned PosW        = 7;
  localparam int unsigned IdxW        = 6;
  localparam int unsigned EscW        = 8;
  localparam int unsigned ArcW        = 33;

  localparam logic [PosW-1:0] NameStart   = 7'd5;
  localparam logic [PosW-1:0] PackedStart = 7'd65;
  localparam logic [PosW-1:0] PlainStart  = 7'd69;
  localparam logic [PosW-1:0] HdrBytes    = 7'd73;
  localparam logic [PosW-1:0] LastPos     = 7'd74;
  localparam logic [SpanW-1:0] MinSpan    = 63'd76;

  localparam logic [7:0] ChrSpace = 8'h20;
  localparam logic [7:0] ChrTilde = 8'h7E;
  localparam logic [7:0] ChrDot   = 8'h2E;

  typedef enum logic [3:0] {
    RsnOk        = 4'd0,
    RsnShort     = 4'd1,
    RsnMagic     = 4'd2,
    RsnNul       = 4'd3,
    RsnNameField = 4'd4,
    RsnZeroSize  = 4'd5,
    RsnPastEnd   = 4'd6,
    RsnTiny      = 4'd7,
    RsnMode      = 4'd8,
    RsnExponent  = 4'd9,
    RsnEmptyName = 4'd10,
    RsnUnsafe    = 4'd11
  } reason_e;

  // Gathered header state as seen by the byte now at the input.
  typedef struct packed {
    logic            last_byte;
    logic            magic_ok;
    logic            nul_ok;
    logic            name_ok;
    logic [31:0]     packed_size;
    logic [31:0]     member_size;
    logic [7:0]      mode_byte;
    logic [IdxW-1:0] raw_len;
    logic [EscW-1:0] esc_len;
    logic [1:0]      dots;
  } scan_t;

  typedef struct packed {
    logic            accepted;
    reason_e         reason;
    logic [31:0]     compressed_bytes;
    logic [31:0]     uncompressed_bytes;
    logic [7:0]      literal_mode;
    logic [7:0]      dictionary_exponent;
    logic [IdxW-1:0] trimmed_name_length;
    logic [EscW-1:0] escaped_name_length;
    logic [ArcW-1:0] archive_bytes;
  } result_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h4A;
      2'd1:    b = 8'h4D;
      2'd2:    b = 8'h39;
      default: b = 8'h33;
    endcase
    return b;
  endfunction

  function automatic logic byte_unsafe(input logic [7:0] c);
    return (c <= ChrSpace) || (c > ChrTilde) ||
           (c inside {8'h25, 8'h2F, 8'h5C, 8'h3A, 8'h2A, 8'h3F, 8'h22, 8'h3C, 8'h3E,
                      8'h7C});
  endfunction

endpackage

// ===== src/cnthdr_scan.sv =====
// Per-byte header scanner: position counter, field flags, sizes and name lengths.
`timescale 1ns / 1ps
module cnthdr_scan (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 take_i,
  input  logic [7:0]           byte_i,
  input  logic                 restart_i,
  output cnthdr_pkg::scan_t    scan_o
);
  import cnthdr_pkg::*;

  logic [PosW-1:0] pos_q, pos_d, pos_c;
  logic            magic_q, magic_d, magic_c;
  logic            nul_q, nul_d, nul_c;
  logic            name_q, name_d, name_c;
  logic            pad_q, pad_d, pad_c;
  logic [31:0]     pk_q, pk_d, pk_c;
  logic [31:0]     pl_q, pl_d, pl_c;
  logic [7:0]      mode_q, mode_d, mode_c;
  logic [IdxW-1:0] raw_q, raw_d, raw_c;
  logic [EscW-1:0] run_q, run_d, run_c;
  logic [EscW-1:0] esc_q, esc_d, esc_c;
  logic [1:0]      dots_q, dots_d, dots_c;
  logic [PosW-1:0] idx_full;
  logic [IdxW-1:0] idx;
  logic [EscW-1:0] run_new;

  always_comb begin
    if (restart_i) begin
      pos_c = '0; magic_c = 1'b1; nul_c = 1'b1; name_c = 1'b1; pad_c = 1'b0;
      pk_c = '0; pl_c = '0; mode_c = '0; raw_c = '0; run_c = '0; esc_c = '0;
      dots_c = '0;
    end else begin
      pos_c = pos_q; magic_c = magic_q; nul_c = nul_q; name_c = name_q; pad_c = pad_q;
      pk_c = pk_q; pl_c = pl_q; mode_c = mode_q; raw_c = raw_q; run_c = run_q;
      esc_c = esc_q; dots_c = dots_q;
    end

    idx_full = pos_c - NameStart;
    idx      = idx_full[IdxW-1:0];
    run_new  = run_c + (byte_unsafe(byte_i) ? EscW'(3) : EscW'(1));

    pos_d = pos_c + 7'd1; magic_d = magic_c; nul_d = nul_c; name_d = name_c;
    pad_d = pad_c; pk_d = pk_c; pl_d = pl_c; mode_d = mode_c; raw_d = raw_c;
    run_d = run_c; esc_d = esc_c; dots_d = dots_c;

    if (pos_c < 7'd4) begin
      if (byte_i != magic_byte(pos_c[1:0])) magic_d = 1'b0;
    end else if (pos_c == 7'd4) begin
      if (byte_i != 8'h00) nul_d = 1'b0;
    end else if (pos_c < PackedStart) begin
      if (byte_i == 8'h00) begin
        if (idx == '0) name_d = 1'b0;
        pad_d = 1'b1;
      end else if (pad_c) begin
        name_d = 1'b0;
      end else begin
        if (byte_i < ChrSpace || byte_i > ChrTilde) name_d = 1'b0;
        if (idx == IdxW'(0) && byte_i == ChrDot) dots_d[0] = 1'b1;
        if (idx == IdxW'(1) && byte_i == ChrDot) dots_d[1] = 1'b1;
        run_d = run_new;
        if (byte_i != ChrSpace) begin
          raw_d = idx + IdxW'(1);
          esc_d = run_new;
        end
      end
    end else if (pos_c < PlainStart) begin
      pk_d = {byte_i, pk_c[31:8]};
    end else if (pos_c < HdrBytes) begin
      pl_d = {byte_i, pl_c[31:8]};
    end else if (pos_c == HdrBytes) begin
      mode_d = byte_i;
    end

    // Verdict byte: start over for the next header.
    if (pos_c == LastPos) begin
      pos_d = '0; magic_d = 1'b1; nul_d = 1'b1; name_d = 1'b1; pad_d = 1'b0;
      pk_d = '0; pl_d = '0; mode_d = '0; raw_d = '0; run_d = '0; esc_d = '0;
      dots_d = '0;
    end

    scan_o.last_byte   = (pos_c == LastPos);
    scan_o.magic_ok    = magic_c;
    scan_o.nul_ok      = nul_c;
    scan_o.name_ok     = name_c;
    scan_o.packed_size = pk_c;
    scan_o.member_size = pl_c;
    scan_o.mode_byte   = mode_c;
    scan_o.raw_len     = raw_c;
    scan_o.esc_len     = esc_c;
    scan_o.dots        = dots_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; magic_q <= 1'b1; nul_q <= 1'b1; name_q <= 1'b1; pad_q <= 1'b0;
      pk_q <= '0; pl_q <= '0; mode_q <= '0; raw_q <= '0; run_q <= '0; esc_q <= '0;
      dots_q <= '0;
    end else if (take_i) begin
      pos_q <= pos_d; magic_q <= magic_d; nul_q <= nul_d; name_q <= name_d;
      pad_q <= pad_d; pk_q <= pk_d; pl_q <= pl_d; mode_q <= mode_d; raw_q <= raw_d;
      run_q <= run_d; esc_q <= esc_d; dots_q <= dots_d;
    end
  end

endmodule

// ===== src/cnthdr_verdict.sv =====
// Verdict logic: ordered format checks over the gathered header state.
`timescale 1ns / 1ps
module cnthdr_verdict (
  input  cnthdr_pkg::scan_t              scan_i,
  input  logic [7:0]                     exp_i,
  input  logic [cnthdr_pkg::SpanW-1:0]   span_i,
  output cnthdr_pkg::result_t            res_o
);
  import cnthdr_pkg::*;

  logic [ArcW-1:0] arc;
  reason_e         rsn;

  assign arc = ArcW'(HdrBytes) + ArcW'(scan_i.packed_size);

  always_comb begin
    if (span_i < MinSpan)                                       rsn = RsnShort;
    else if (!scan_i.magic_ok)                                  rsn = RsnMagic;
    else if (!scan_i.nul_ok)                                    rsn = RsnNul;
    else if (!scan_i.name_ok)                                   rsn = RsnNameField;
    else if (scan_i.packed_size == '0 || scan_i.member_size == '0) rsn = RsnZeroSize;
    else if (SpanW'(arc) > span_i)                              rsn = RsnPastEnd;
    else if (scan_i.packed_size < 32'd3)                        rsn = RsnTiny;
    else if (scan_i.mode_byte > 8'd1)                           rsn = RsnMode;
    else if (exp_i < 8'd4 || exp_i > 8'd6)                      rsn = RsnExponent;
    else if (scan_i.raw_len == '0)                              rsn = RsnEmptyName;
    else if (scan_i.raw_len == IdxW'(2) && scan_i.dots == 2'b11) rsn = RsnUnsafe;
    else                                                        rsn = RsnOk;

    res_o.accepted            = (rsn == RsnOk);
    res_o.reason              = rsn;
    res_o.compressed_bytes    = scan_i.packed_size;
    res_o.uncompressed_bytes  = scan_i.member_size;
    res_o.literal_mode        = scan_i.mode_byte;
    res_o.dictionary_exponent = exp_i;
    res_o.trimmed_name_length = scan_i.raw_len;
    res_o.escaped_name_length = scan_i.esc_len;
    res_o.archive_bytes       = arc;
  end

endmodule

// ===== src/container_header_checker.sv =====
// Top level: stream ports, span register on APB, scanner, verdict and result register.
//
//  channel   | direction | transaction
//  s_axis    | in        | one header byte, tuser[0] = restart
//  m_axis    | out       | one verdict after header offset 74
//  apb       | in        | file_span write/read at address 0
//
//  One byte per cycle unless stalled; offset 74 being taken registers a verdict.
//  The result register holds the verdict until m_axis_tready; input is taken
//  whenever that register is empty or being drained.
//  Reset clears the scanner to offset zero and file_span to zero.
`timescale 1ns / 1ps
module container_header_checker (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] header_byte
  input  logic [0:0]   s_axis_tuser,   // [0] restart
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] accepted, [4:1] reject_reason, [36:5] compressed_bytes,
  // [68:37] uncompressed_bytes, [76:69] literal_mode, [84:77] dictionary_exponent,
  // [90:85] trimmed_name_length, [98:91] escaped_name_length,
  // [131:99] archive_bytes, [135:132] zero
  output logic [135:0] m_axis_tdata,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [63:0]  pwdata,
  output logic [63:0]  prdata,
  output logic         pready
);
  import cnthdr_pkg::*;

  logic [SpanW-1:0] span_q;
  logic             ovalid_q;
  result_t          res_q, res_d;
  scan_t            scan;
  logic             take;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == 1'b0) ? {1'b0, span_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      span_q <= '0;
    end else if (psel && penable && pwrite && !paddr[3]) begin
      span_q <= pwdata[SpanW-1:0];
    end
  end

  assign s_axis_tready = !ovalid_q || m_axis_tready;
  assign take          = s_axis_tvalid && s_axis_tready;

  cnthdr_scan u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .byte_i    (s_axis_tdata),
    .restart_i (s_axis_tuser[0]),
    .scan_o    (scan)
  );

  cnthdr_verdict u_verdict (
    .scan_i (scan),
    .exp_i  (s_axis_tdata),
    .span_i (span_q),
    .res_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (take && scan.last_byte) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && scan.last_byte) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {4'b0000, res_q.archive_bytes, res_q.escaped_name_length,
                          res_q.trimmed_name_length, res_q.dictionary_exponent,
                          res_q.literal_mode, res_q.uncompressed_bytes,
                          res_q.compressed_bytes, res_q.reason, res_q.accepted};

`ifndef SYNTHESIS
  a_accept_matches_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> (res_q.accepted == (res_q.reason == RsnOk)))
    else $error("accepted flag disagrees with reject reason");

  a_archive_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> (res_q.archive_bytes == ArcW'(HdrBytes) + ArcW'(res_q.compressed_bytes)))
    else $error("archive size is not header plus compressed size");

  a_escaped_covers_trimmed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q |-> (res_q.escaped_name_length >= EscW'(res_q.trimmed_name_length)))
    else $error("escaped name shorter than trimmed name");

  a_restart_no_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && s_axis_tuser[0]) |=> !$rose(ovalid_q))
    else $error("verdict produced on a restart byte");
`endif

endmodule
